@@ rtl/core/rsde_pkg.sv @@
// Shared constants, types and command/status structs for the register
// snapshot delta encoder. No dependencies; all files but rsde_out_if and rsde_checker refer to it.
package rsde_pkg;

  // Number of sampled registers and the width of an index over them.
  localparam int NUM_REGS = 10;
  localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Register data, address and timestamp widths, plus delta, varint and zigzag widths.
  localparam int DATA_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int TIME_W   = 64;
  localparam int DT_W     = 32;
  localparam int VINT_W   = 32;
  localparam int ZZ_W     = DATA_W + 1;

  // Configuration: mask register width, reset and legal bits.
  localparam int                 MASK_W      = 10;
  localparam logic [MASK_W-1:0]  MASK_RESET  = 10'h3FF;
  localparam logic [15:0]        MASK_BITS   = 16'h03FF;
  localparam logic [15:0]        EXIST_MASK  =
    (NUM_REGS >= 16) ? 16'hFFFF : 16'((32'd1 << NUM_REGS) - 32'd1);

  // APB register map: one 32-bit register, byte address 4*index.
  localparam int               APB_ADDR_W   = 3;
  localparam int               APB_DATA_W   = 32;
  localparam logic             REG_MASK_IDX = 1'b0;

  // Varint continuation flag.
  localparam logic [7:0] CONT_BIT = 8'h80;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             store_sample;
    logic             load_time;
    logic             emit_vint;
    logic             emit_mask_lo;
    logic             emit_mask_hi;
    logic             load_reg;
    logic             copy_reg;
    logic             emit_last;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit_ok;
    logic vint_last;
    logic reg_sel;
    logic more_regs;
    logic mask_zero;
  } sts_t;

endpackage

@@ rtl/core/rsde_in_if.sv @@
// Input channel of the encoder: one sample or record-end beat per handshake.
// Depends on rsde_pkg for field widths.
interface rsde_in_if;
  logic                             valid;
  logic                             ready;
  logic [rsde_pkg::TIME_W-1:0]      record_time;
  logic [rsde_pkg::ADDR_W-1:0]      reg_addr;
  logic [rsde_pkg::DATA_W-1:0]      reg_data;
  logic                             has_sample;
  logic                             record_end;

  modport source (output valid, record_time, reg_addr, reg_data, has_sample, record_end,
                  input ready);
  modport sink   (input valid, record_time, reg_addr, reg_data, has_sample, record_end,
                  output ready);
endinterface

@@ rtl/core/rsde_out_if.sv @@
// Output channel of the encoder: one encoded byte per beat.
// No dependencies.
interface rsde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

@@ rtl/core/rsde_cfg.sv @@
// APB-style configuration register block holding the register mask.
// Depends on rsde_pkg for the register map.
module rsde_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rsde_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rsde_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rsde_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [rsde_pkg::MASK_W-1:0]        reg_mask
);

  logic [rsde_pkg::MASK_W-1:0] reg_mask_r;
  logic                        hit;

  // Word index decode; the low two address bits are ignored.
  assign hit = (paddr[rsde_pkg::APB_ADDR_W-1:2] == rsde_pkg::REG_MASK_IDX);

  // The mask is written in the access phase of a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_mask_r <= rsde_pkg::MASK_RESET;
    end else if (psel && penable && pwrite && hit) begin
      reg_mask_r <= pwdata[rsde_pkg::MASK_W-1:0];
    end
  end

  // Read data and a port that never waits.
  assign prdata   = hit ? rsde_pkg::APB_DATA_W'(reg_mask_r) : '0;
  assign pready   = 1'b1;
  assign reg_mask = reg_mask_r;

endmodule

@@ rtl/core/rsde_ctrl.sv @@
// Controller state machine of the encoder: sequences time, mask and per-register
// emission. Depends on rsde_pkg for the command and status structs.
module rsde_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_has_sample,
  input  logic             in_record_end,
  input  rsde_pkg::sts_t   sts,
  output rsde_pkg::cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TIME = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_REG  = 3'd4;
  localparam logic [2:0] ST_RVAR = 3'd5;

  localparam logic [rsde_pkg::IDX_W-1:0] IDX_LAST =
    rsde_pkg::IDX_W'(rsde_pkg::NUM_REGS - 1);

  logic [2:0]                 state_r, state_nxt;
  logic [rsde_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state, index walk and datapath commands.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.store_sample = in_has_sample;
          if (in_record_end) begin
            cmd.load_time = 1'b1;
            state_nxt     = ST_TIME;
          end
        end
      end
      ST_TIME: begin
        if (sts.emit_ok) begin
          cmd.emit_vint = 1'b1;
          if (sts.vint_last) begin
            state_nxt = ST_MLO;
          end
        end
      end
      ST_MLO: begin
        if (sts.emit_ok) begin
          cmd.emit_mask_lo = 1'b1;
          state_nxt        = ST_MHI;
        end
      end
      ST_MHI: begin
        if (sts.emit_ok) begin
          cmd.emit_mask_hi = 1'b1;
          cmd.emit_last    = sts.mask_zero;
          idx_nxt          = '0;
          state_nxt        = ST_REG;
        end
      end
      ST_REG: begin
        // A selected register loads its zigzag delta; others fall back to last value.
        if (sts.reg_sel) begin
          cmd.load_reg = 1'b1;
          state_nxt    = ST_RVAR;
        end else begin
          cmd.copy_reg = 1'b1;
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_RVAR: begin
        if (sts.emit_ok) begin
          cmd.emit_vint = 1'b1;
          cmd.emit_last = sts.vint_last && !sts.more_regs;
          if (sts.vint_last) begin
            if (idx_r == IDX_LAST) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = ST_REG;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

@@ rtl/core/rsde_dp.sv @@
// Datapath of the encoder: sample store, last values, time delta, zigzag,
// varint shifter and output register. Depends on rsde_pkg.
module rsde_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rsde_pkg::cmd_t                  cmd,
  output rsde_pkg::sts_t                  sts,
  input  logic [rsde_pkg::MASK_W-1:0]     reg_mask,
  input  logic [rsde_pkg::TIME_W-1:0]     in_time,
  input  logic [rsde_pkg::ADDR_W-1:0]     in_addr,
  input  logic [rsde_pkg::DATA_W-1:0]     in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);

  logic [rsde_pkg::DATA_W-1:0] snap_r [rsde_pkg::NUM_REGS];
  logic [rsde_pkg::DATA_W-1:0] last_r [rsde_pkg::NUM_REGS];
  logic [rsde_pkg::TIME_W-1:0] prev_time_r;
  logic                        first_r;
  logic [rsde_pkg::VINT_W-1:0] vint_r, vint_nxt;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_last_r;

  logic [15:0]                  eff_mask;
  logic [rsde_pkg::TIME_W-1:0]  time_diff;
  logic [rsde_pkg::DT_W-1:0]    dt;
  logic [rsde_pkg::DATA_W-1:0]  snap_sel, last_sel;
  logic signed [rsde_pkg::ZZ_W-1:0] diff;
  logic [rsde_pkg::ZZ_W:0]      zz;
  logic                         emit;
  logic                         more;
  logic                         addr_ok;

  // Mask limited to legal bits and existing registers.
  assign eff_mask = 16'(reg_mask) & rsde_pkg::MASK_BITS & rsde_pkg::EXIST_MASK;

  // Timestamp delta: zero on the first record or when time goes backwards.
  assign time_diff = in_time - prev_time_r;
  assign dt = (first_r || (in_time < prev_time_r)) ? '0 : time_diff[rsde_pkg::DT_W-1:0];

  // Zigzag of the signed difference between the snapshot and the last value.
  assign snap_sel = snap_r[cmd.idx];
  assign last_sel = last_r[cmd.idx];
  assign diff = $signed({snap_sel[rsde_pkg::DATA_W-1], snap_sel})
              - $signed({last_sel[rsde_pkg::DATA_W-1], last_sel});
  assign zz   = {diff, 1'b0} ^ {(rsde_pkg::ZZ_W + 1){diff[rsde_pkg::ZZ_W-1]}};

  // Any selected register above the current index still to come.
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < rsde_pkg::NUM_REGS; i++) begin
      if ((rsde_pkg::IDX_W'(i) > cmd.idx) && eff_mask[i]) begin
        more = 1'b1;
      end
    end
  end

  assign addr_ok = (in_addr < rsde_pkg::ADDR_W'(rsde_pkg::NUM_REGS));

  // Output beat can be loaded when the register is empty or being drained.
  assign emit = cmd.emit_vint || cmd.emit_mask_lo || cmd.emit_mask_hi;

  assign sts.emit_ok   = !out_valid_r || out_ready;
  assign sts.vint_last = (vint_r[rsde_pkg::VINT_W-1:7] == '0);
  assign sts.reg_sel   = eff_mask[cmd.idx];
  assign sts.more_regs = more;
  assign sts.mask_zero = (eff_mask == '0);

  // Varint shifter and the byte it offers.
  always_comb begin
    vint_nxt     = vint_r;
    out_byte_nxt = out_byte_r;
    if (cmd.load_time) begin
      vint_nxt = rsde_pkg::VINT_W'(dt);
    end else if (cmd.load_reg) begin
      vint_nxt = rsde_pkg::VINT_W'(zz[rsde_pkg::ZZ_W-1:0]);
    end else if (cmd.emit_vint) begin
      vint_nxt = vint_r >> 7;
    end
    if (cmd.emit_vint) begin
      out_byte_nxt = {1'b0, vint_r[6:0]} | (sts.vint_last ? 8'h00 : rsde_pkg::CONT_BIT);
    end else if (cmd.emit_mask_lo) begin
      out_byte_nxt = eff_mask[7:0];
    end else if (cmd.emit_mask_hi) begin
      out_byte_nxt = eff_mask[15:8];
    end
  end

  // Payload registers: varint, output byte and its last flag.
  always_ff @(posedge clk) begin
    vint_r <= vint_nxt;
    if (emit) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= cmd.emit_last;
    end
  end

  // Record state: snapshot, last values, previous time and first-record flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rsde_pkg::NUM_REGS; i++) begin
        snap_r[i] <= '0;
        last_r[i] <= '0;
      end
      prev_time_r <= '0;
      first_r     <= 1'b1;
    end else begin
      if (cmd.store_sample && addr_ok) begin
        snap_r[in_addr[rsde_pkg::IDX_W-1:0]] <= in_data;
      end
      if (cmd.load_time) begin
        prev_time_r <= in_time;
        first_r     <= 1'b0;
      end
      if (cmd.load_reg) begin
        last_r[cmd.idx] <= snap_sel;
      end
      if (cmd.copy_reg) begin
        snap_r[cmd.idx] <= last_sel;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/register_snapshot_delta_encoder.sv @@
// Register snapshot delta encoder. An input beat with record_end starts emission
// of the record: 1 to 5 varint bytes of the 32-bit timestamp delta, two bytes of
// the effective mask, then a zigzag varint (1 to 3 bytes) for each selected
// register in ascending order. The controller emits the bytes one at a time and
// walks the register file one register per step; a selected register loads its
// delta in its own walk step, and byte emission waits while the output stalls.
// Input is taken again once the walk finishes; the last byte may still sit in
// the output register. The mask register is at byte address 0 of the APB port.
module register_snapshot_delta_encoder (
  input  logic                               clk,
  input  logic                               rst_n,
  rsde_in_if.sink                            in_if,
  rsde_out_if.source                         out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rsde_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rsde_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rsde_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  rsde_pkg::cmd_t              cmd;
  rsde_pkg::sts_t              sts;
  logic [rsde_pkg::MASK_W-1:0] reg_mask;

  // Configuration register.
  rsde_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .reg_mask (reg_mask)
  );

  // Sequencer.
  rsde_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_has_sample (in_if.has_sample),
    .in_record_end (in_if.record_end),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Datapath.
  rsde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .reg_mask  (reg_mask),
    .in_time   (in_if.record_time),
    .in_addr   (in_if.reg_addr),
    .in_data   (in_if.reg_data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_byte  (out_if.out_byte),
    .out_last  (out_if.last_byte)
  );

endmodule

@@ rtl/core/rsde_checker.sv @@
// Port-level checks for the register snapshot delta encoder, bound to the top
// level. Depends only on the top level's ports.
module rsde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_record_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled output beat keeps its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output beat changed while stalled");

  // A record end stops input while the record is encoded.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_record_end |=> !in_ready)
    else $error("input taken right after a record end");

  // A plain sample beat leaves the input open.
  a_sample_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_record_end |=> in_ready)
    else $error("input closed after a sample beat");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind register_snapshot_delta_encoder rsde_checker u_rsde_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_record_end (in_if.record_end),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_byte      (out_if.out_byte),
  .out_last      (out_if.last_byte)
);

@@ tb/register_snapshot_delta_encoder_tb.sv @@
// Self-checking testbench for the register snapshot delta encoder: a byte-stream
// predictor checks every encoded record beat, with random idling on both channels.
// Depends on rsde_pkg, rsde_in_if, rsde_out_if and the encoder top level.
module register_snapshot_delta_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_PHASES      = 6;

  // One expected beat of the encoded stream.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  // Predicts the encoded byte stream from accepted sample beats and checks
  // the encoder output against it in order.
  class record_stream_model;
    logic [rsde_pkg::DATA_W-1:0] last_vals [rsde_pkg::NUM_REGS];
    logic [rsde_pkg::DATA_W-1:0] snap [rsde_pkg::NUM_REGS];
    logic [rsde_pkg::TIME_W-1:0] prev_time;
    logic                        first_rec;
    logic [15:0]                 reg_mask;
    enc_byte_t                   pending [$];
    logic [7:0]                  rec_bytes [$];
    int                          errors;

    function new();
      foreach (last_vals[i]) begin
        last_vals[i] = '0;
        snap[i] = '0;
      end
      prev_time = '0;
      first_rec = 1'b1;
      reg_mask = 16'(rsde_pkg::MASK_RESET);
      errors = 0;
    endfunction

    function void set_mask(logic [rsde_pkg::APB_DATA_W-1:0] value);
      reg_mask = value[15:0] & rsde_pkg::MASK_BITS;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t %s", $time, what);
    endfunction

    // Seven bits per byte, low group first, continuation in bit 7.
    function void add_varint(logic [31:0] v);
      while (v >= 32'(rsde_pkg::CONT_BIT)) begin
        rec_bytes = {rec_bytes, (v[7:0] & 8'h7F) | rsde_pkg::CONT_BIT};
        v = v >> 7;
      end
      rec_bytes = {rec_bytes, v[7:0]};
    endfunction

    // Zigzag code of the difference of two signed 16-bit values.
    function logic [31:0] zigzag(logic [rsde_pkg::DATA_W-1:0] now,
                                 logic [rsde_pkg::DATA_W-1:0] was);
      int d;
      d = int'($signed(now)) - int'($signed(was));
      if (d >= 0) return 32'(d) << 1;
      return (32'(-d) << 1) - 32'd1;
    endfunction

    function void take_beat(logic [rsde_pkg::TIME_W-1:0] t,
                            logic [rsde_pkg::ADDR_W-1:0] addr,
                            logic [rsde_pkg::DATA_W-1:0] data, logic has, logic endr);
      logic [31:0] dt;
      logic [15:0] em;
      enc_byte_t   eb;
      if (has && addr < rsde_pkg::NUM_REGS) snap[addr] = data;
      if (!endr) return;

      // Timestamp delta is zero on the first record and when time runs back.
      if (first_rec || t < prev_time) dt = '0;
      else dt = 32'(t - prev_time);
      prev_time = t;
      first_rec = 1'b0;
      em = reg_mask & rsde_pkg::MASK_BITS & rsde_pkg::EXIST_MASK;

      rec_bytes.delete();
      add_varint(dt);
      rec_bytes = {rec_bytes, em[7:0]};
      rec_bytes = {rec_bytes, em[15:8]};
      for (int r = 0; r < rsde_pkg::NUM_REGS; r++) begin
        if (em[r]) begin
          add_varint(zigzag(snap[r], last_vals[r]));
          last_vals[r] = snap[r];
        end
      end
      // Unselected registers fall back to their last emitted value.
      foreach (snap[r]) snap[r] = last_vals[r];

      foreach (rec_bytes[i]) begin
        eb.value = rec_bytes[i];
        eb.last = (i == rec_bytes.size() - 1);
        pending = {pending, eb};
      end
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      enc_byte_t eb;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected byte %02h last %0b", value, last));
        return;
      end
      eb = pending.pop_front();
      if (value !== eb.value || last !== eb.last)
        flag($sformatf("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       eb.value, eb.last, value, last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rsde_pkg::APB_ADDR_W-1:0] paddr;
  logic [rsde_pkg::APB_DATA_W-1:0] pwdata;
  logic [rsde_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  rsde_in_if  in_ch ();
  rsde_out_if out_ch ();

  record_stream_model          model;
  logic [rsde_pkg::TIME_W-1:0] clock_ms;
  logic                        in_burst;
  logic                        hold_pending;
  int                          idle_cycles = 0;

  register_snapshot_delta_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channel monitors plus the no-progress counter for the watchdog.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) model.check_byte(out_ch.out_byte, out_ch.last_byte);
    if (in_ch.valid && in_ch.ready)
      model.take_beat(in_ch.record_time, in_ch.reg_addr, in_ch.reg_data,
                      in_ch.has_sample, in_ch.record_end);
    if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
        (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls per beat, burst stretches and one long hold-off.
  initial begin
    int gap;
    int beats;
    logic out_burst;
    logic held;
    beats = 0;
    out_burst = 1'b0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (beats % 16 == 0) out_burst = ($urandom_range(0, 3) == 0);
      if (hold_pending && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = out_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      beats++;
    end
  end

  // Offer one beat after a random gap and wait for it to be taken.
  task automatic send_beat(input logic [rsde_pkg::TIME_W-1:0] t,
                           input logic [rsde_pkg::ADDR_W-1:0] addr,
                           input logic [rsde_pkg::DATA_W-1:0] data, input logic has,
                           input logic endr);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.record_time <= t;
    in_ch.reg_addr    <= addr;
    in_ch.reg_data    <= data;
    in_ch.has_sample  <= has;
    in_ch.record_end  <= endr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mask write: setup phase, then access phase until pready.
  task automatic write_mask(input logic [rsde_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rsde_pkg::APB_ADDR_W'(4 * int'(rsde_pkg::REG_MASK_IDX));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.set_mask(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every expected byte has come out and the encoder has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [rsde_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return rsde_pkg::DATA_W'($urandom);
    endcase
  endfunction

  // Next record time: mostly small steps, sometimes steps that need long
  // varints, wraps past 32 bits, jumps anywhere, or time running back.
  function automatic logic [rsde_pkg::TIME_W-1:0] next_time();
    logic [rsde_pkg::TIME_W-1:0] t;
    case ($urandom_range(0, 9))
      0: t = clock_ms - rsde_pkg::TIME_W'($urandom_range(1, 1000));
      1: t = {$urandom, $urandom};
      2: t = clock_ms + {32'($urandom_range(1, 3)), 32'($urandom)};
      3: t = clock_ms + rsde_pkg::TIME_W'($urandom);
      4: t = clock_ms + rsde_pkg::TIME_W'($urandom_range(0, 1 << 21));
      5, 6: t = clock_ms + rsde_pkg::TIME_W'($urandom_range(0, 16383));
      default: t = clock_ms + rsde_pkg::TIME_W'($urandom_range(0, 127));
    endcase
    return t;
  endfunction

  // One record of random samples closed by an end beat. Every beat offered
  // adds to the count.
  task automatic send_random_record(inout int counted);
    int n;
    logic [rsde_pkg::ADDR_W-1:0] addr;
    logic [rsde_pkg::TIME_W-1:0] t;
    n = $urandom_range(0, 5);
    in_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_beat({$urandom, $urandom}, rsde_pkg::ADDR_W'($urandom), pick_data(),
                     1'b0, 1'b0);
        1: send_beat({$urandom, $urandom},
                     rsde_pkg::ADDR_W'($urandom_range(rsde_pkg::NUM_REGS, 65535)),
                     pick_data(), 1'b1, 1'b0);
        default: send_beat({$urandom, $urandom},
                           rsde_pkg::ADDR_W'($urandom_range(0, rsde_pkg::NUM_REGS - 1)),
                           pick_data(), 1'b1, 1'b0);
      endcase
      counted++;
    end
    t = next_time();
    addr = ($urandom_range(0, 7) == 0) ?
           rsde_pkg::ADDR_W'($urandom) :
           rsde_pkg::ADDR_W'($urandom_range(0, rsde_pkg::NUM_REGS - 1));
    send_beat(t, addr, pick_data(), 1'($urandom_range(0, 1)), 1'b1);
    clock_ms = t;
    counted++;
  endtask

  initial begin
    logic [rsde_pkg::APB_DATA_W-1:0] mask_plan [NUM_PHASES];
    int counted;
    model = new();
    hold_pending = 1'b0;
    in_burst = 1'b0;
    clock_ms = '0;
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.record_time <= '0;
    in_ch.reg_addr    <= '0;
    in_ch.reg_data    <= '0;
    in_ch.has_sample  <= 1'b0;
    in_ch.record_end  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records under the reset mask.
    // Empty first record: zero time delta, all deltas zero.
    send_beat(64'd100, 16'd0, 16'd0, 1'b0, 1'b1);
    // Extreme values, ignored addresses, a no-op beat and a repeated address.
    send_beat(64'd0, 16'd0, 16'h7FFF, 1'b1, 1'b0);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 16'h8000, 1'b1, 1'b0);
    send_beat(64'd0, 16'd9, 16'hFFFF, 1'b1, 1'b0);
    send_beat(64'd0, 16'(rsde_pkg::NUM_REGS), 16'h1234, 1'b1, 1'b0);
    send_beat(64'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_beat(64'd0, 16'd0, 16'hFFFF, 1'b0, 1'b0);
    send_beat(64'd0, 16'd0, 16'h8000, 1'b1, 1'b0);
    // Sample on the end beat, one-byte time delta of 127.
    send_beat(64'd227, 16'd2, 16'h0001, 1'b1, 1'b1);
    // Largest positive swing on register 0, two-byte time delta.
    send_beat(64'd355, 16'd0, 16'h7FFF, 1'b1, 1'b1);
    // Jump to the top of time: delta cut to its low 32 bits.
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'd3, 16'h0000, 1'b1, 1'b1);
    // Time running back to zero.
    send_beat(64'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    // Five-byte time delta and a negative swing down to 16'h8000.
    send_beat(64'h0000_0000_FFFF_FFFF, 16'd4, 16'h8000, 1'b1, 1'b1);
    send_beat(64'h0000_0002_0000_0010, 16'd5, 16'hFFFF, 1'b1, 1'b1);
    // Same time again.
    send_beat(64'h0000_0002_0000_0010, 16'd6, 16'h7FFF, 1'b1, 1'b1);
    clock_ms = 64'h0000_0002_0000_0010;
    drain();

    // Random phases, each under its own mask; mask writes carry upper bits too.
    mask_plan[0] = 32'h0000_0000;
    mask_plan[1] = 32'h0000_0155;
    mask_plan[2] = $urandom;
    mask_plan[3] = 32'hFFFF_FE00;
    mask_plan[4] = 32'h0000_0001;
    mask_plan[5] = 32'hFFFF_FFFF;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mask(mask_plan[p]);
      if (p == 2) hold_pending = 1'b1;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) send_random_record(counted);
      drain();
    end

    if (model.errors == 0 && model.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
